### design/fbab_pkg.sv
// fbab_pkg: shared constants, types and pixel helpers for the RGB565 pixel store.
// Used by every module of rgb565_framebuffer_alpha_blend_unit but the checker. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbab_pkg;

	localparam int DEF_WIDTH  = 320;
	localparam int DEF_HEIGHT = 320;

	localparam int COORD_W = 12;
	localparam int CH_W    = 8;
	localparam int PIX_W   = 16;
	localparam int PROD_W  = 16;
	localparam int LIN_W   = 22;

	localparam logic [1:0] OP_SET  = 2'd0;
	localparam logic [1:0] OP_GET  = 2'd1;
	localparam logic [1:0] OP_FILL = 2'd2;

	localparam logic [CH_W-1:0] ALPHA_MAX = 8'd255;

	typedef struct packed {
		logic [CH_W-1:0] b;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] r;
	} rgb_t;

	function automatic logic [PIX_W-1:0] pack565(input rgb_t c);
		pack565 = {c.r[7:3], c.g[7:2], c.b[7:3]};
	endfunction

	function automatic rgb_t expand565(input logic [PIX_W-1:0] w);
		rgb_t c;
		c.r = {w[15:11], 3'b000};
		c.g = {w[10:5], 2'b00};
		c.b = {w[4:0], 3'b000};
		expand565 = c;
	endfunction

	// exact x/255 for any x up to 65279, where the quotient fits 8 bits
	function automatic logic [CH_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W:0] t;
		logic [PROD_W:0] s;
		t = {1'b0, x} + 17'd1;
		s = t + (t >> 8);
		div255 = s[15:8];
	endfunction

endpackage

`default_nettype wire

### design/fbab_ram.sv
// fbab_ram: single-clock pixel memory, one write port, one registered read port.
// Depends on fbab_pkg for the word width.
`timescale 1ns / 1ps
`default_nettype none

module fbab_ram #(
	parameter int DEPTH = 1,
	parameter int AW    = 1
) (
	input  wire logic                      clk,
	input  wire logic                      we,
	input  wire logic [AW-1:0]             waddr,
	input  wire logic [fbab_pkg::PIX_W-1:0] wdata,
	input  wire logic [AW-1:0]             raddr,
	output logic      [fbab_pkg::PIX_W-1:0] rdata
);
	import fbab_pkg::*;

	logic [PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/fbab_blend.sv
// fbab_blend: per-channel alpha blend of a source colour over a stored RGB565 word.
// Products are registered, then summed, divided by 255 and repacked. Depends on fbab_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbab_blend (
	input  wire logic                      clk,
	input  wire logic [fbab_pkg::CH_W-1:0] alpha,
	input  wire fbab_pkg::rgb_t            src,
	input  wire logic [fbab_pkg::PIX_W-1:0] dst,
	output logic      [fbab_pkg::PIX_W-1:0] result
);
	import fbab_pkg::*;

	rgb_t              dst_c;
	logic [CH_W-1:0]   inv_a;
	logic [PROD_W-1:0] ps_r_s1, ps_g_s1, ps_b_s1;
	logic [PROD_W-1:0] pd_r_s1, pd_g_s1, pd_b_s1;
	rgb_t              mix_c;

	assign dst_c = expand565(dst);
	assign inv_a = ALPHA_MAX - alpha;

	always_ff @(posedge clk) begin
		ps_r_s1 <= PROD_W'(alpha) * PROD_W'(src.r);
		ps_g_s1 <= PROD_W'(alpha) * PROD_W'(src.g);
		ps_b_s1 <= PROD_W'(alpha) * PROD_W'(src.b);
		pd_r_s1 <= PROD_W'(inv_a) * PROD_W'(dst_c.r);
		pd_g_s1 <= PROD_W'(inv_a) * PROD_W'(dst_c.g);
		pd_b_s1 <= PROD_W'(inv_a) * PROD_W'(dst_c.b);
	end

	// sums stay below 65026, so 16 bits hold them
	always_comb begin
		mix_c.r = div255(ps_r_s1 + pd_r_s1);
		mix_c.g = div255(ps_g_s1 + pd_g_s1);
		mix_c.b = div255(ps_b_s1 + pd_b_s1);
	end

	assign result = pack565(mix_c);

endmodule

`default_nettype wire

### design/rgb565_framebuffer_alpha_blend_unit.sv
// rgb565_framebuffer_alpha_blend_unit: RGB565 pixel store with set/blend, get and fill.
// Depends on fbab_pkg, fbab_ram, fbab_blend.
//
// channel   dir  handshake                 payload
// s_axis    in   s_axis_tvalid/tready      op, x, y, red, green, blue, opacity
// m_axis    out  m_axis_tvalid/tready      red_out, green_out, blue_out
//
// One item at a time, read-modify-write through the single-port-pair memory.
// Set: ST_READ, writing there if opaque; ignored items end there. Blend adds ST_MIX and
// ST_WB. Get: ST_READ, then ST_GET until the output register is free. Fill: ST_FILL,
// one word per cycle. A clearing pass after reset writes black to all WIDTH*HEIGHT
// words, accepting no item until done. A held get result stalls only the next get.
`timescale 1ns / 1ps
`default_nettype none

module rgb565_framebuffer_alpha_blend_unit #(
	parameter int WIDTH  = fbab_pkg::DEF_WIDTH,
	parameter int HEIGHT = fbab_pkg::DEF_HEIGHT
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// [1:0] operation, [13:2] pos_x, [25:14] pos_y, [33:26] red_in,
	// [41:34] green_in, [49:42] blue_in, [57:50] opacity, [63:58] zero
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [7:0] red_out, [15:8] green_out, [23:16] blue_out
	output logic      [23:0] m_axis_tdata
);
	import fbab_pkg::*;

	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_MIX,
		ST_WB,
		ST_GET,
		ST_FILL
	} state_t;

	state_t state_q;

	logic [1:0]         in_op;
	logic [COORD_W-1:0] in_x, in_y;
	rgb_t               in_c;
	logic [CH_W-1:0]    in_a;
	logic               in_hit;
	logic [10:0]        row;
	logic [LIN_W-1:0]   lin;
	logic [AW-1:0]      in_idx;

	logic [1:0]      op_q;
	logic            hit_q;
	logic [AW-1:0]   idx_q;
	rgb_t            col_q;
	logic [CH_W-1:0] alpha_q;
	logic [AW-1:0]   cnt_q;
	logic [23:0]     out_q;
	logic            out_valid_q;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [PIX_W-1:0] ram_wdata;
	logic [PIX_W-1:0] ram_rdata;
	logic [PIX_W-1:0] blend_word;
	rgb_t             rd_c;
	logic             sweep_last;

	assign in_op  = s_axis_tdata[1:0];
	assign in_x   = s_axis_tdata[13:2];
	assign in_y   = s_axis_tdata[25:14];
	assign in_c.r = s_axis_tdata[33:26];
	assign in_c.g = s_axis_tdata[41:34];
	assign in_c.b = s_axis_tdata[49:42];
	assign in_a   = s_axis_tdata[57:50];

	assign in_hit = !in_x[COORD_W-1] && (in_x[10:0] < 11'(WIDTH))
		&& !in_y[COORD_W-1] && (in_y[10:0] < 11'(HEIGHT));
	assign row    = 11'(HEIGHT - 1) - in_y[10:0];
	assign lin    = LIN_W'(row) * LIN_W'(WIDTH) + LIN_W'(in_x[10:0]);
	assign in_idx = in_hit ? lin[AW-1:0] : '0;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_q;
	assign sweep_last    = (cnt_q == AW'(DEPTH - 1));
	assign rd_c          = expand565(ram_rdata);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = pack565(col_q);
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = '0;
			end
			ST_READ: begin
				ram_we = (op_q == OP_SET) && hit_q && (alpha_q == ALPHA_MAX);
			end
			ST_WB: begin
				ram_we    = 1'b1;
				ram_wdata = blend_word;
			end
			ST_FILL: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a waiting get loads the output register as soon as it is free
			if (state_q == ST_GET) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						op_q    <= in_op;
						hit_q   <= in_hit;
						idx_q   <= in_idx;
						col_q   <= in_c;
						alpha_q <= in_a;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					cnt_q <= '0;
					case (op_q)
						OP_SET: begin
							if (hit_q && (alpha_q != '0) && (alpha_q != ALPHA_MAX)) begin
								state_q <= ST_MIX;
							end else begin
								state_q <= ST_IDLE;
							end
						end
						OP_GET:  state_q <= ST_GET;
						OP_FILL: state_q <= ST_FILL;
						default: state_q <= ST_IDLE;
					endcase
				end
				ST_MIX: begin
					state_q <= ST_WB;
				end
				ST_WB: begin
					state_q <= ST_IDLE;
				end
				ST_GET: begin
					if (!out_valid_q || m_axis_tready) begin
						out_q   <= hit_q ? {rd_c.b, rd_c.g, rd_c.r} : '0;
						state_q <= ST_IDLE;
					end
				end
				ST_FILL: begin
					cnt_q <= cnt_q + 1'b1;
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	fbab_ram #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	fbab_blend u_blend (
		.clk   (clk),
		.alpha (alpha_q),
		.src   (col_q),
		.dst   (ram_rdata),
		.result(blend_word)
	);

endmodule

`default_nettype wire

### design/fbab_checker.sv
// fbab_checker: port-level assertions for rgb565_framebuffer_alpha_blend_unit, with bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module fbab_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [63:0] s_axis_tdata,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [23:0] m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result item changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("second item accepted while one is in flight");

	a_expanded: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2:0] == 3'b000) && (m_axis_tdata[9:8] == 2'b00)
			&& (m_axis_tdata[18:16] == 3'b000))
		else $error("result channels not expanded from RGB565");

	a_quick_noop: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tdata[1:0] == 2'd3) |-> ##2 s_axis_tready)
		else $error("unused operation did not return to ready");

endmodule

bind rgb565_framebuffer_alpha_blend_unit fbab_checker u_fbab_checker (.*);

`default_nettype wire
